### hdl/icmp_echo_reply_checker_macros.svh
// Assertion macros for the ICMP echo reply checker.
// Included by the files that assert; depends on nothing else.
`ifndef ICMP_ECHO_REPLY_CHECKER_MACROS_SVH
`define ICMP_ECHO_REPLY_CHECKER_MACROS_SVH
`ifndef SYNTHESIS
`define IERC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ierc assertion failed");
`define IERC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ierc assertion failed");
`else
`define IERC_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define IERC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### hdl/ierc_pkg.sv
// Shared constants, status codes and the per-datagram summary record
// of the ICMP echo reply checker. Depends on nothing.
`default_nettype none
package ierc_pkg;

	localparam int OFFSET_WIDTH = 16;
	localparam logic [OFFSET_WIDTH-1:0] OFFSET_TOP = '1;
	localparam int MIN_ICMP_BYTES = 8;
	localparam logic [7:0] ECHO_REPLY_TYPE = 8'd0;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_TOO_SHORT  = 3'd1,
		ST_CSUM_ERR   = 3'd2,
		ST_NOT_REPLY  = 3'd3,
		ST_FOREIGN_ID = 3'd4
	} status_t;

	// Everything the back end needs to judge one finished datagram.
	typedef struct packed {
		logic [OFFSET_WIDTH-1:0] last_offset;
		logic [5:0]              header_bytes;
		logic [15:0]             datagram_length;
		logic [31:0]             word_sum;
		logic [8:0]              held_low_byte;
		logic [7:0]              reply_type;
		logic [15:0]             reply_ident;
		logic [15:0]             reply_seq;
		logic [31:0]             sent_stamp;
		logic [31:0]             now_ms;
	} summary_t;

endpackage
`default_nettype wire

### hdl/icmp_echo_reply_checker.sv
// Top level of the ICMP echo reply checker: front end, summary queue and
// back end. Depends on ierc_pkg and icmp_echo_reply_checker_macros.svh.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------------------
//   input    | in_valid / in_stall  | data_byte, last_byte, now_ms
//   result   | out_valid/ out_stall | status, sequence_res, round_trip_ms, ...
//   config   | cfg_write            | cfg_data (own identifier)
//
// One byte is taken every cycle unless in_stall is high; the front end's per-byte sum
// and capture set that rate. After its last byte is taken, a result passes the queue,
// two check stages and the output register before it is offered.
// A four-entry summary queue lets the input run on while results are stalled;
// in_stall rises only when that queue is full. Reset clears the offset, the queue,
// the pipeline valids and the statistics at once, but sets rtt_minimum to 0xFFFF.
`default_nettype none
`include "icmp_echo_reply_checker_macros.svh"
module icmp_echo_reply_checker import ierc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	input  logic [31:0] now_ms,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [15:0] sequence_res,
	output logic [31:0] round_trip_ms,
	output logic [15:0] payload_bytes,
	output logic [31:0] replies_received,
	output logic [31:0] rtt_minimum,
	output logic [31:0] rtt_maximum,
	output logic [31:0] rtt_total
);

	logic     accept, push, pop, q_full, q_empty;
	summary_t summary, head;
	logic        ok_out, bad_out, fail_zeroed, rtt_in_range, result_held;
	logic [63:0] stats_pair;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	ierc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.now_ms    (now_ms),
		.push      (push),
		.summary   (summary)
	);

	ierc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (summary),
		.pop       (pop),
		.full      (q_full),
		.empty     (q_empty),
		.head      (head)
	);

	ierc_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write        (cfg_write),
		.cfg_data         (cfg_data),
		.entry_valid      (!q_empty),
		.entry            (head),
		.pop              (pop),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.status           (status),
		.sequence_res     (sequence_res),
		.round_trip_ms    (round_trip_ms),
		.payload_bytes    (payload_bytes),
		.replies_received (replies_received),
		.rtt_minimum      (rtt_minimum),
		.rtt_maximum      (rtt_maximum),
		.rtt_total        (rtt_total)
	);

	assign ok_out       = out_valid && (status == ST_OK);
	assign bad_out      = out_valid && (status != ST_OK);
	assign fail_zeroed  = (round_trip_ms == 32'd0) && (payload_bytes == 16'd0);
	assign rtt_in_range = (rtt_minimum <= round_trip_ms) && (rtt_maximum >= round_trip_ms);
	assign result_held  = out_valid && out_stall;
	assign stats_pair   = {replies_received, rtt_total};

	// A rejected datagram reports no round trip and no payload length.
	`IERC_ASSERT_NOW(a_fail_zeroed, clk, arst_n, bad_out, fail_zeroed)
	// A good reply always lies within the updated minimum and maximum.
	`IERC_ASSERT_NOW(a_ok_in_range, clk, arst_n, ok_out, rtt_in_range)
	// Statistics stay put while a result waits to be taken.
	`IERC_ASSERT_NEXT(a_stats_hold, clk, arst_n, result_held, $stable(stats_pair))
	// The queue is never written while it is full.
	`IERC_ASSERT_NOW(a_no_push_full, clk, arst_n, q_full, !push)

endmodule
`default_nettype wire

### hdl/ierc_front.sv
// Front end: walks the datagram byte by byte, sums the ICMP words and
// captures the echo fields. Depends on ierc_pkg.
`default_nettype none
module ierc_front import ierc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	input  logic [31:0] now_ms,
	output logic       push,
	output summary_t   summary
);

	logic [OFFSET_WIDTH-1:0] off_q, off_n, rel;
	logic [5:0]  hb_q, hb_n;
	logic [15:0] dl_q, dl_n;
	logic [31:0] ws_q, ws_n, ws_cur;
	logic [8:0]  held_q, held_n, held_cur;
	logic [7:0]  type_q, type_n;
	logic [15:0] ident_q, ident_n, seq_q, seq_n;
	logic [31:0] stamp_q, stamp_n;
	logic        first, live, in_icmp;

	always_comb begin
		first = (off_q == '0);
		live  = (off_q != OFFSET_TOP);
		// The start of a datagram clears everything kept for the previous one.
		ws_cur   = first ? 32'd0 : ws_q;
		held_cur = first ? 9'd0 : held_q;
		type_n   = first ? 8'd0 : type_q;
		ident_n  = first ? 16'd0 : ident_q;
		seq_n    = first ? 16'd0 : seq_q;
		stamp_n  = first ? 32'd0 : stamp_q;
		hb_n     = first ? {data_byte[3:0], 2'b00} : hb_q;
		priority if (first) begin
			dl_n = 16'd0;
		end else if (off_q == OFFSET_WIDTH'(2)) begin
			dl_n = {data_byte, dl_q[7:0]};
		end else if (off_q == OFFSET_WIDTH'(3)) begin
			dl_n = {dl_q[15:8], data_byte};
		end else begin
			dl_n = dl_q;
		end
		in_icmp = live && (off_q >= OFFSET_WIDTH'(hb_n))
			&& ((off_q < OFFSET_WIDTH'(4)) || (16'(off_q) < dl_n));
		rel    = off_q - OFFSET_WIDTH'(hb_n);
		ws_n   = ws_cur;
		held_n = held_cur;
		if (in_icmp) begin
			if (rel[0]) begin
				ws_n   = ws_cur + {16'd0, data_byte, held_cur[7:0]};
				held_n = 9'd0;
			end else begin
				held_n = {1'b1, data_byte};
			end
			if (rel == OFFSET_WIDTH'(0))
				type_n = data_byte;
			if (rel == OFFSET_WIDTH'(4))
				ident_n[7:0] = data_byte;
			if (rel == OFFSET_WIDTH'(5))
				ident_n[15:8] = data_byte;
			if (rel == OFFSET_WIDTH'(6))
				seq_n[7:0] = data_byte;
			if (rel == OFFSET_WIDTH'(7))
				seq_n[15:8] = data_byte;
			if (rel[OFFSET_WIDTH-1:2] == (OFFSET_WIDTH-2)'(2)) begin
				unique case (rel[1:0])
					2'd0: stamp_n[7:0]   = data_byte;
					2'd1: stamp_n[15:8]  = data_byte;
					2'd2: stamp_n[23:16] = data_byte;
					2'd3: stamp_n[31:24] = data_byte;
				endcase
			end
		end
		if (last_byte)
			off_n = '0;
		else if (live)
			off_n = off_q + OFFSET_WIDTH'(1);
		else
			off_n = off_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= '0;
		end else if (accept) begin
			off_q <= off_n;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hb_q    <= hb_n;
			dl_q    <= dl_n;
			ws_q    <= ws_n;
			held_q  <= held_n;
			type_q  <= type_n;
			ident_q <= ident_n;
			seq_q   <= seq_n;
			stamp_q <= stamp_n;
		end
	end

	assign push = accept && last_byte;

	always_comb begin
		summary.last_offset     = off_q;
		summary.header_bytes    = hb_n;
		summary.datagram_length = dl_n;
		summary.word_sum        = ws_n;
		summary.held_low_byte   = held_n;
		summary.reply_type      = type_n;
		summary.reply_ident     = ident_n;
		summary.reply_seq       = seq_n;
		summary.sent_stamp      = stamp_n;
		summary.now_ms          = now_ms;
	end

endmodule
`default_nettype wire

### hdl/ierc_queue.sv
// Short queue of datagram summaries between the front and back ends.
// Depends on ierc_pkg.
`default_nettype none
module ierc_queue import ierc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  summary_t push_data,
	input  logic     pop,
	output logic     full,
	output logic     empty,
	output summary_t head
);

	summary_t          mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push, do_pop;

	assign full    = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= wr_q + QPTR_W'(1);
			if (do_pop)
				rd_q <= rd_q + QPTR_W'(1);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + QCNT_W'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - QCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= push_data;
	end

endmodule
`default_nettype wire

### hdl/ierc_back.sv
// Back end: checks each datagram summary, works out the round trip and
// keeps the reply statistics behind an output register. Depends on ierc_pkg.
`default_nettype none
module ierc_back import ierc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [15:0] cfg_data,
	input  logic        entry_valid,
	input  summary_t    entry,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [15:0] sequence_res,
	output logic [31:0] round_trip_ms,
	output logic [15:0] payload_bytes,
	output logic [31:0] replies_received,
	output logic [31:0] rtt_minimum,
	output logic [31:0] rtt_maximum,
	output logic [31:0] rtt_total
);

	logic [15:0] own_id_q;
	logic        adv;

	logic        v_s1, short_s1, type_ok_s1, ident_ok_s1;
	logic [31:0] sum_s1, rtt_s1;
	logic [15:0] payload_s1, seq_s1;

	logic        v_s2;
	status_t     status_s2, status_n;
	logic [31:0] rtt_s2;
	logic [15:0] payload_s2, seq_s2;
	logic [16:0] fold;
	logic        csum_ok;

	logic        out_valid_q;
	status_t     status_q;
	logic [15:0] seq_q, payload_q;
	logic [31:0] rtt_q, count_q, min_q, max_q, total_q;

	// The whole back end moves together whenever the output register can take an item.
	assign adv = !out_valid_q || !out_stall;
	assign pop = adv && entry_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q <= 16'd0;
		end else if (cfg_write) begin
			own_id_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
			count_q     <= 32'd0;
			min_q       <= 32'h0000_FFFF;
			max_q       <= 32'd0;
			total_q     <= 32'd0;
		end else if (adv) begin
			v_s1        <= entry_valid;
			v_s2        <= v_s1;
			out_valid_q <= v_s2;
			if (v_s2 && (status_s2 == ST_OK)) begin
				count_q <= count_q + 32'd1;
				total_q <= total_q + rtt_s2;
				if (min_q > rtt_s2)
					min_q <= rtt_s2;
				if (max_q < rtt_s2)
					max_q <= rtt_s2;
			end
		end
	end

	// Stage 1: final word sum, length check, field compares, round trip, payload length.
	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s1 <= entry.word_sum
				+ (entry.held_low_byte[8] ? {24'd0, entry.held_low_byte[7:0]} : 32'd0);
			short_s1 <= 16'(entry.last_offset)
				< 16'(7'({1'b0, entry.header_bytes}) + 7'(MIN_ICMP_BYTES - 1));
			type_ok_s1  <= (entry.reply_type == ECHO_REPLY_TYPE);
			ident_ok_s1 <= (entry.reply_ident == own_id_q);
			rtt_s1      <= entry.now_ms - entry.sent_stamp;
			payload_s1  <= entry.datagram_length - 16'(entry.header_bytes)
				- 16'(MIN_ICMP_BYTES);
			seq_s1      <= entry.reply_seq;
		end
	end

	// Stage 2: fold the sum to 16 bits and pick the status. The folded complement is zero exactly
	// when the end-around-carry result is all ones.
	always_comb begin
		fold    = {1'b0, sum_s1[31:16]} + {1'b0, sum_s1[15:0]};
		csum_ok = ((fold[15:0] == 16'hFFFF) && !fold[16])
			|| ((fold[15:0] == 16'hFFFE) && fold[16]);
		priority if (short_s1)
			status_n = ST_TOO_SHORT;
		else if (!csum_ok)
			status_n = ST_CSUM_ERR;
		else if (!type_ok_s1)
			status_n = ST_NOT_REPLY;
		else if (!ident_ok_s1)
			status_n = ST_FOREIGN_ID;
		else
			status_n = ST_OK;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_s2  <= status_n;
			rtt_s2     <= (status_n == ST_OK) ? rtt_s1 : 32'd0;
			payload_s2 <= (status_n == ST_OK) ? payload_s1 : 16'd0;
			seq_s2     <= seq_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s2) begin
			status_q  <= status_s2;
			rtt_q     <= rtt_s2;
			payload_q <= payload_s2;
			seq_q     <= seq_s2;
		end
	end

	// Statistics change only when a new result loads, so they read out directly.
	assign out_valid        = out_valid_q;
	assign status           = status_q;
	assign sequence_res     = seq_q;
	assign round_trip_ms    = rtt_q;
	assign payload_bytes    = payload_q;
	assign replies_received = count_q;
	assign rtt_minimum      = min_q;
	assign rtt_maximum      = max_q;
	assign rtt_total        = total_q;

endmodule
`default_nettype wire
